### hdl/ppw_pkg.sv
// ppw_pkg: shared types and constants for the projective pixel warp
// no dependencies
package ppw_pkg;
    localparam int COEF_W   = 40;
    localparam int NUM_COEF = 8;
    localparam int IDX_W    = 3;
    localparam int CRD_W    = 12;
    localparam int DIM_W    = 13;
    localparam int PIX_W    = 8;
    localparam int MAX_DIM  = 4096;
    localparam int PROD_W   = COEF_W + CRD_W + 1;   // signed coef * unsigned coord
    localparam int SUM_W    = 54;                   // three-term sums stay below 2^53
    localparam int QUO_W    = 18;                   // quotient bits kept for the range check
    localparam logic signed [COEF_W-1:0] Q_ONE = 40'sd16777216;

    typedef enum logic [IDX_W-1:0] {
        REG_XX = 3'd0, REG_XY = 3'd1, REG_XO = 3'd2,
        REG_YX = 3'd3, REG_YY = 3'd4, REG_YO = 3'd5,
        REG_WX = 3'd6, REG_WY = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] xn;
        logic signed [SUM_W-1:0] yn;
        logic signed [SUM_W-1:0] den;
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
        logic [PIX_W-1:0]        val;
    } job_t;
endpackage

### hdl/ppw_front.sv
// ppw_front: coefficient registers and numerator/denominator pipeline
// depends on ppw_pkg
module ppw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [39:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [11:0]                 src_col,
    input  logic [11:0]                 src_row,
    input  logic [7:0]                  pixel_value,
    input  logic [12:0]                 frame_width,
    input  logic [12:0]                 frame_height,
    output logic                        job_valid,
    output ppw_pkg::job_t               job,
    input  logic                        job_stall
);
    import ppw_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    // stage 1: products
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] p_reg [6];
    logic [DIM_W-1:0]         s1_w_reg, s1_h_reg;
    logic [PIX_W-1:0]         s1_val_reg;
    // stage 2: sums
    logic                     s2_valid_reg;
    job_t                     s2_reg;
    logic                     adv1, adv2;
    logic [DIM_W-1:0]         w_cl, h_cl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= '0;
            coef_reg[REG_XX] <= Q_ONE;
            coef_reg[REG_YY] <= Q_ONE;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    assign adv2     = !s2_valid_reg || !job_stall;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    assign w_cl = (frame_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width;
    assign h_cl = (frame_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            p_reg[0]   <= coef_reg[REG_XX] * $signed({1'b0, src_col});
            p_reg[1]   <= coef_reg[REG_XY] * $signed({1'b0, src_row});
            p_reg[2]   <= coef_reg[REG_YX] * $signed({1'b0, src_col});
            p_reg[3]   <= coef_reg[REG_YY] * $signed({1'b0, src_row});
            p_reg[4]   <= coef_reg[REG_WX] * $signed({1'b0, src_col});
            p_reg[5]   <= coef_reg[REG_WY] * $signed({1'b0, src_row});
            s1_w_reg   <= w_cl;
            s1_h_reg   <= h_cl;
            s1_val_reg <= pixel_value;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_reg.xn  <= SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]) + SUM_W'(coef_reg[REG_XO]);
            s2_reg.yn  <= SUM_W'(p_reg[2]) + SUM_W'(p_reg[3]) + SUM_W'(coef_reg[REG_YO]);
            s2_reg.den <= SUM_W'(p_reg[4]) + SUM_W'(p_reg[5]) + SUM_W'(Q_ONE);
            s2_reg.w   <= s1_w_reg;
            s2_reg.h   <= s1_h_reg;
            s2_reg.val <= s1_val_reg;
        end
    end

    assign job_valid = s2_valid_reg;
    assign job       = s2_reg;

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_stall |=> job_valid)
        else $error("job dropped while stalled");
    ap_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv2 |=> s1_valid_reg)
        else $error("stage one lost an item");
    ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg)
        else $error("stall without full pipe");
endmodule

### hdl/ppw_queue.sv
// ppw_queue: two-entry queue between front and back
// depends on ppw_pkg
module ppw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_stall,
    input  ppw_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_stall,
    output ppw_pkg::job_t rd_job
);
    import ppw_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];
    assign wr       = wr_valid && !wr_stall;
    assign rd       = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_job;
    end

    ap_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    ap_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wp_reg != rp_reg))
        else $error("queue pointers out of step");
    ap_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("queue pointers out of step");
endmodule

### hdl/ppw_back.sv
// ppw_back: pipelined restoring dividers, range check and output register
// depends on ppw_pkg
module ppw_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_stall,
    input  ppw_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [11:0]   dst_col,
    output logic [11:0]   dst_row,
    output logic [7:0]    dst_value
);
    import ppw_pkg::*;

    localparam int MAG_W = SUM_W;          // magnitudes fit in 53 bits, one spare
    localparam int NST   = QUO_W;          // one quotient bit per stage
    // quotients of >= 2^QUO_W are out of range anyway; flag them as overflow

    typedef struct packed {
        logic [MAG_W-1:0] dx;   // remaining dividend x
        logic [MAG_W-1:0] dy;
        logic [MAG_W-1:0] dv;   // divisor magnitude
        logic [QUO_W-1:0] qx;
        logic [QUO_W-1:0] qy;
        logic             nx;   // quotient negative
        logic             ny;
        logic             ovx;
        logic             ovy;
        logic             zero;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [PIX_W-1:0] val;
    } div_t;

    div_t st_reg [NST+1];
    div_t st_next [NST+1];
    logic [NST:0] vld_reg;
    div_t st_in;
    logic adv;
    logic out_valid_reg;
    logic [11:0] col_reg, row_reg;
    logic [7:0]  val_reg;
    logic [MAG_W-1:0] ax, ay, ad;
    logic [MAG_W-1:0] lim;
    div_t lst;
    logic hit;

    assign adv       = !out_valid_reg || !out_stall;
    assign job_stall = !adv;

    assign ax = job.xn[SUM_W-1] ? MAG_W'(-job.xn) : MAG_W'(job.xn);
    assign ay = job.yn[SUM_W-1] ? MAG_W'(-job.yn) : MAG_W'(job.yn);
    assign ad = job.den[SUM_W-1] ? MAG_W'(-job.den) : MAG_W'(job.den);
    assign lim = ad << QUO_W;

    always_comb
    begin
        st_in      = '0;
        st_in.dx   = ax;
        st_in.dy   = ay;
        st_in.dv   = ad;
        st_in.nx   = job.xn[SUM_W-1] ^ job.den[SUM_W-1];
        st_in.ny   = job.yn[SUM_W-1] ^ job.den[SUM_W-1];
        st_in.zero = (ad == '0);
        // quotient of 2^QUO_W or more; a divisor too big to shift safely gives none, so no flag
        st_in.ovx  = (ad[MAG_W-1 -: QUO_W] != '0) ? 1'b0 : (ax >= lim);
        st_in.ovy  = (ad[MAG_W-1 -: QUO_W] != '0) ? 1'b0 : (ay >= lim);
        st_in.w    = job.w;
        st_in.h    = job.h;
        st_in.val  = job.val;
    end

    // each stage resolves one quotient bit, msb first
    always_comb
    begin
        st_next[0] = st_in;
        for (int i = 1; i <= NST; i++)
        begin
            st_next[i] = st_reg[i-1];
            if (!st_reg[i-1].ovx && ((st_reg[i-1].dx >> (NST-i)) >= st_reg[i-1].dv))
            begin
                st_next[i].dx = st_reg[i-1].dx - (st_reg[i-1].dv << (NST-i));
                st_next[i].qx[NST-i] = 1'b1;
            end
            if (!st_reg[i-1].ovy && ((st_reg[i-1].dy >> (NST-i)) >= st_reg[i-1].dv))
            begin
                st_next[i].dy = st_reg[i-1].dy - (st_reg[i-1].dv << (NST-i));
                st_next[i].qy[NST-i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-1:0], job_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= NST; i++)
                st_reg[i] <= st_next[i];
        end
    end

    assign lst = st_reg[NST];
    assign hit = vld_reg[NST] && !lst.zero && !lst.ovx && !lst.ovy && !lst.nx && !lst.ny
               && (lst.qx != '0) && (lst.qy != '0)
               && ({1'b0, lst.qx} < (QUO_W+1)'(lst.w))
               && ({1'b0, lst.qy} < (QUO_W+1)'(lst.h));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= hit;
    end

    always_ff @(posedge clk)
    begin
        if (adv && hit)
        begin
            col_reg <= lst.qx[11:0];
            row_reg <= lst.qy[11:0];
            val_reg <= lst.val;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_col   = col_reg;
    assign dst_row   = row_reg;
    assign dst_value = val_reg;

    ap_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dst_col))
        else $error("result lost under stall");
    ap_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dst_col != 12'd0 && dst_row != 12'd0)
        else $error("edge target emitted");
    ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
        job_stall |-> out_valid)
        else $error("back stalls with empty output");
endmodule

### hdl/projective_pixel_warp.sv
// projective_pixel_warp: top level of the forward-mapping pixel warp
// depends on ppw_pkg, ppw_front, ppw_queue, ppw_back
//
// One source pixel per clock in while in_stall is low, zero or one frame-buffer
// write out. The front forms a11*x+a21*y+a31, a12*x+a22*y+a32 and a13*x+a23*y+1
// in two stages (product, sum); a two-entry queue then feeds the back, an 18-stage
// fully pipelined restoring divider resolving one quotient bit per stage for both
// coordinates at once, followed by the range check and output register; without
// output stalls it sustains one pixel per cycle. Writes with a zero denominator or
// a target that is negative, in row or column zero or off the frame are dropped.
// The user must write coefficients only while the block is idle (not enforced).
module projective_pixel_warp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] src_col,
    input  logic [11:0] src_row,
    input  logic [7:0]  pixel_value,
    input  logic [12:0] frame_width,
    input  logic [12:0] frame_height,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] dst_col,
    output logic [11:0] dst_row,
    output logic [7:0]  dst_value
);
    import ppw_pkg::*;

    // front to queue
    logic f_valid, f_stall;
    job_t f_job;
    // queue to back
    logic b_valid, b_stall;
    job_t b_job;

    ppw_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .src_col, .src_row, .pixel_value,
        .frame_width, .frame_height,
        .job_valid(f_valid), .job(f_job), .job_stall(f_stall)
    );

    ppw_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_job(b_job)
    );

    ppw_back u_back (
        .clk, .rst_n,
        .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
        .out_valid, .out_stall, .dst_col, .dst_row, .dst_value
    );
endmodule

### bench/projective_pixel_warp_tb.sv
// projective_pixel_warp_tb: self-checking bench for the projective pixel warp
// depends on ppw_pkg and projective_pixel_warp; predicts each frame-buffer write
// in plain 64-bit arithmetic and compares every output transfer in order
module projective_pixel_warp_tb;
    import ppw_pkg::*;

    // fixed-point one in the coefficient format
    localparam longint QONE = 64'sd16777216;
    localparam int DRAIN = 40;

    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  val;
    } fb_write_t;

    // one directed row: coefficient set is applied before the pixel when load is set
    typedef struct {
        bit          load;
        longint      c[8];
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  v;
        logic [12:0] w;
        logic [12:0] h;
        int          known;   // -1 use predictor, 0 no write, 1 write at kx/ky
        int          kx;
        int          ky;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [39:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] src_col = '0;
    logic [11:0] src_row = '0;
    logic [7:0]  pixel_value = '0;
    logic [12:0] frame_width = '0;
    logic [12:0] frame_height = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] dst_col;
    logic [11:0] dst_row;
    logic [7:0]  dst_value;

    // testbench copy of the coefficient registers
    longint    coef_shadow[8];
    fb_write_t pending_writes[$];
    int        error_count = 0;
    bit        no_stall_phase = 1'b0;

    projective_pixel_warp dut (.*);

    always #4 clk = ~clk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic longint sext40(input logic [39:0] v);
        return longint'($signed(v));
    endfunction

    // map a pixel through the matrix; returns 1 for a write in frame, off row/col 0
    function automatic bit warp_pixel(input logic [11:0] x, input logic [11:0] y,
                                      input logic [7:0] v, input logic [12:0] w,
                                      input logic [12:0] h, output fb_write_t wr);
        longint xs, ys, xn, yn, den, qx, qy, wl, hl;
        xs = longint'(x);
        ys = longint'(y);
        wl = (w > 13'd4096) ? 4096 : longint'(w);
        hl = (h > 13'd4096) ? 4096 : longint'(h);
        xn = coef_shadow[REG_XX] * xs + coef_shadow[REG_XY] * ys + coef_shadow[REG_XO];
        yn = coef_shadow[REG_YX] * xs + coef_shadow[REG_YY] * ys + coef_shadow[REG_YO];
        den = coef_shadow[REG_WX] * xs + coef_shadow[REG_WY] * ys + QONE;
        wr = '{default: '0};
        if (den == 0)
            return 1'b0;
        qx = xn / den;   // sv division of integers truncates toward zero
        qy = yn / den;
        if (qx <= 0 || qy <= 0 || qx >= wl || qy >= hl)
            return 1'b0;
        wr.col = qx[11:0];
        wr.row = qy[11:0];
        wr.val = v;
        return 1'b1;
    endfunction

    task automatic write_coef(input reg_idx_t idx, input longint value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[39:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        coef_shadow[idx] = sext40(value[39:0]);
    endtask

    // wait for idle: every expected write has come out, then let the pipe drain
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_coefs(input longint c[8]);
        drain_pipe();
        for (int i = 0; i < 8; i++)
            write_coef(reg_idx_t'(i), c[i]);
    endtask

    // send one pixel, with a random gap before it; queue the predicted write
    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
                              input logic [7:0] v, input logic [12:0] w,
                              input logic [12:0] h, input int known,
                              input int kx, input int ky);
        fb_write_t wr;
        bit        hit;
        int        gap;
        gap = no_stall_phase ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        src_col <= x;
        src_row <= y;
        pixel_value <= v;
        frame_width <= w;
        frame_height <= h;
        hit = warp_pixel(x, y, v, w, h, wr);
        if (known == 0 && hit)
            report("directed row expects no write but predictor gives one");
        if (known == 1 && !(hit && wr.col == kx[11:0] && wr.row == ky[11:0]))
            report("directed row expected write disagrees with predictor");
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer done at this edge
        if (hit)
            pending_writes.push_back(wr);
    endtask

    // output side: random stall per transfer, compare against the oldest expectation
    initial
    begin
        int hold;
        forever
        begin
            hold = no_stall_phase ? 0 : $urandom_range(0, 16);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_writes.size() == 0)
                report("unexpected frame-buffer write");
            else
            begin
                fb_write_t exp_wr;
                exp_wr = pending_writes.pop_front();
                if (dst_col !== exp_wr.col)
                    report($sformatf("dst_col %0d expected %0d", dst_col, exp_wr.col));
                if (dst_row !== exp_wr.row)
                    report($sformatf("dst_row %0d expected %0d", dst_row, exp_wr.row));
                if (dst_value !== exp_wr.val)
                    report($sformatf("dst_value %0d expected %0d", dst_value, exp_wr.val));
            end
        end
    end

    // random coefficient set, mostly near an affine or mild perspective map
    function automatic void pick_coefs(output longint c[8]);
        int mode;
        mode = $urandom_range(0, 9);
        c[REG_XX] = QONE + longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        c[REG_XY] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        c[REG_XO] = (longint'($urandom_range(0, 2000)) - 500) * QONE
                    + longint'($urandom_range(0, (1 << 24) - 1));
        c[REG_YX] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        c[REG_YY] = QONE + longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        c[REG_YO] = (longint'($urandom_range(0, 2000)) - 500) * QONE
                    + longint'($urandom_range(0, (1 << 24) - 1));
        c[REG_WX] = longint'($urandom_range(0, 8000)) - 4000;
        c[REG_WY] = longint'($urandom_range(0, 8000)) - 4000;
        if (mode == 0)
        begin
            // full random 40-bit patterns in every coefficient
            for (int i = 0; i < 8; i++)
                c[i] = sext40({$urandom(), 8'($urandom())});
        end
        else if (mode == 1)
        begin
            // denominator crosses zero inside the source range
            c[REG_WX] = -(QONE / 64);
            c[REG_WY] = 0;
        end
    endfunction

    localparam longint MAXC = 64'sd549755813887;
    localparam longint MINC = -64'sd549755813888;

    vec_t dir_rows[$];

    initial
    begin
        longint ident[8];
        longint c[8];
        logic [12:0] fw, fh;
        ident = '{QONE, 0, 0, 0, QONE, 0, 0, 0};
        coef_shadow = ident;

        // identity after reset: plain copy, edges and clamps
        dir_rows.push_back('{0, ident, 12'd5, 12'd7, 8'd200, 13'd64, 13'd48, 1, 5, 7});
        dir_rows.push_back('{0, ident, 12'd0, 12'd7, 8'd1, 13'd64, 13'd48, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd5, 12'd0, 8'd2, 13'd64, 13'd48, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd63, 12'd47, 8'd255, 13'd64, 13'd48, 1, 63, 47});
        dir_rows.push_back('{0, ident, 12'd64, 12'd10, 8'd3, 13'd64, 13'd48, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd10, 12'd48, 8'd4, 13'd64, 13'd48, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd4095, 12'd4095, 8'd0, 13'd8191, 13'd8191,
                             1, 4095, 4095});
        dir_rows.push_back('{0, ident, 12'd4095, 12'd1, 8'd9, 13'd4096, 13'd4096,
                             1, 4095, 1});
        dir_rows.push_back('{0, ident, 12'd1, 12'd1, 8'd9, 13'd1, 13'd1, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd1, 12'd1, 8'd9, 13'd0, 13'd0, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd1, 12'd1, 8'd170, 13'd2, 13'd2, 1, 1, 1});
        // shift by a negative offset: target goes negative
        dir_rows.push_back('{1, '{QONE, 0, -100 * QONE, 0, QONE, -3 * QONE, 0, 0},
                             12'd50, 12'd20, 8'd85, 13'd640, 13'd480, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd150, 12'd20, 8'd85, 13'd640, 13'd480,
                             1, 50, 17});
        // swap axes
        dir_rows.push_back('{1, '{0, QONE, 0, QONE, 0, 0, 0, 0},
                             12'd9, 12'd30, 8'd77, 13'd100, 13'd100, 1, 30, 9});
        // halving via the denominator: doubled map over a denominator of 1 + x/4096
        dir_rows.push_back('{1, '{2 * QONE, 0, 0, 0, 2 * QONE, 0, QONE / 4096, 0},
                             12'd0, 12'd0, 8'd1, 13'd100, 13'd100, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd4095, 12'd2000, 8'd1, 13'd4096, 13'd4096,
                             -1, 0, 0});
        // zero denominator: a13 = -1/16, x = 16
        dir_rows.push_back('{1, '{QONE, 0, QONE, 0, QONE, QONE, -(QONE / 16), 0},
                             12'd16, 12'd5, 8'd33, 13'd100, 13'd100, 0, 0, 0});
        dir_rows.push_back('{0, ident, 12'd17, 12'd5, 8'd33, 13'd100, 13'd100,
                             -1, 0, 0});
        dir_rows.push_back('{0, ident, 12'd15, 12'd5, 8'd33, 13'd100, 13'd100,
                             -1, 0, 0});
        // coefficient extremes
        dir_rows.push_back('{1, '{MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC},
                             12'd4095, 12'd4095, 8'd255, 13'd4096, 13'd4096, -1, 0, 0});
        dir_rows.push_back('{0, ident, 12'd4095, 12'd0, 8'd255, 13'd4096, 13'd4096,
                             -1, 0, 0});
        dir_rows.push_back('{0, ident, 12'd0, 12'd4095, 8'd255, 13'd4096, 13'd4096,
                             -1, 0, 0});
        dir_rows.push_back('{1, '{MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC},
                             12'd1, 12'd0, 8'd0, 13'd4096, 13'd4096, -1, 0, 0});
        dir_rows.push_back('{1, '{-QONE, 0, 0, 0, -QONE, 0, 0, 0},
                             12'd3, 12'd3, 8'd0, 13'd10, 13'd10, 0, 0, 0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].load)
                load_coefs(dir_rows[i].c);
            send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].v, dir_rows[i].w,
                       dir_rows[i].h, dir_rows[i].known, dir_rows[i].kx, dir_rows[i].ky);
        end

        // random frames: a coefficient set, then a run of pixels in one frame
        for (int frame = 0; frame < 25; frame++)
        begin
            pick_coefs(c);
            load_coefs(c);
            no_stall_phase = (frame % 6 == 5);
            fw = (frame % 8 == 7) ? 13'($urandom()) : 13'($urandom_range(2, 4096));
            fh = (frame % 8 == 7) ? 13'($urandom()) : 13'($urandom_range(2, 4096));
            for (int n = 0; n < 50; n++)
                send_pixel(12'($urandom_range(0, fw > 4096 ? 4095 : fw)),
                           12'($urandom_range(0, fh > 4096 ? 4095 : fh)),
                           8'($urandom()), fw, fh, -1, 0, 0);
        end
        no_stall_phase = 1'b0;

        drain_pipe();
        if (error_count == 0)
            $display("projective_pixel_warp_tb: clean");
        else
            $display("projective_pixel_warp_tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("projective_pixel_warp_tb: errors");
        $finish;
    end
endmodule

### filelist.f
hdl/ppw_pkg.sv
hdl/ppw_front.sv
hdl/ppw_queue.sv
hdl/ppw_back.sv
hdl/projective_pixel_warp.sv
bench/projective_pixel_warp_tb.sv
